// ----- design/tolerant_repeat_suppression_filter_defines.svh -----
// ----------------------------------------------------------------------------
// tolerant_repeat_suppression_filter_defines
// Assertion macros shared by the filter modules.
// ----------------------------------------------------------------------------
`ifndef TOLERANT_REPEAT_SUPPRESSION_FILTER_DEFINES_SVH
`define TOLERANT_REPEAT_SUPPRESSION_FILTER_DEFINES_SVH

// Check that an antecedent implies a consequent on the next clock.
`define TRSF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Check that a condition holds on every clock outside reset.
`define TRSF_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

`endif

// ----- design/trsf_pkg.sv -----
// ----------------------------------------------------------------------------
// trsf_pkg
// Types and constants shared by the repeat suppression filter modules.
// ----------------------------------------------------------------------------
package trsf_pkg;

  localparam logic [2:0] REG_MIN_REPEAT = 3'd0;
  localparam logic [2:0] REG_FREQ_TOL   = 3'd1;
  localparam logic [2:0] REG_STR_TOL    = 3'd2;
  localparam logic [2:0] REG_LOC_TOL    = 3'd3;
  localparam logic [2:0] REG_CAPTURE    = 3'd4;

  // One alert as seen by the compare and commit logic.
  typedef struct packed {
    logic [31:0]        ts;
    logic [7:0]         band;
    logic [15:0]        freq;
    logic [7:0]         strength;
    logic               loc_valid;
    logic signed [24:0] lat;
    logic signed [25:0] lon;
  } alert_t;

  // Work item handed from the front to the back.
  typedef struct packed {
    alert_t     alert;
    logic       keep;       // passes validity and band checks
    logic       supported;
    logic       last;
  } work_t;

  // Configuration values.
  typedef struct packed {
    logic [15:0] min_repeat;
    logic [9:0]  freq_tol;
    logic [3:0]  str_tol;
    logic [15:0] loc_tol;
    logic        capture;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESULT,
    ST_COMMIT
  } back_state_t;

endpackage

// ----- design/trsf_front.sv -----
// ----------------------------------------------------------------------------
// trsf_front
// Accept alerts, classify them and queue them for the back end.
// ----------------------------------------------------------------------------
module trsf_front
  import trsf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        in_timestamp_ms,
  input  logic               in_alert_valid,
  input  logic [7:0]         in_band_code,
  input  logic               in_band_supported,
  input  logic [7:0]         in_front_strength,
  input  logic [7:0]         in_rear_strength,
  input  logic [15:0]        in_frequency_mhz,
  input  logic               in_location_valid,
  input  logic signed [24:0] in_latitude_e5,
  input  logic signed [25:0] in_longitude_e5,
  input  logic               in_frame_last,
  input  logic               capture,
  output logic               q_valid,
  input  logic               q_pop,
  output work_t              q_data
);

  `include "tolerant_repeat_suppression_filter_defines.svh"

  // Two-entry queue.
  work_t      mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  work_t      w;
  logic       push;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = mem_r[rp_r];

  always_comb begin
    w.alert.ts        = in_timestamp_ms;
    w.alert.band      = in_band_code;
    w.alert.freq      = in_frequency_mhz;
    w.alert.strength  = (in_front_strength > in_rear_strength) ?
                        in_front_strength : in_rear_strength;
    w.alert.loc_valid = in_location_valid;
    w.alert.lat       = in_location_valid ? in_latitude_e5 : '0;
    w.alert.lon       = in_location_valid ? in_longitude_e5 : '0;
    w.keep            = in_alert_valid && (in_band_supported || capture);
    w.supported       = in_band_supported;
    w.last            = in_frame_last;
  end

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = q_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= w;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  `TRSF_ASSERT_ALWAYS(a_no_pop_empty, clk, rst_n, !(q_pop && cnt_r == 2'd0),
    "pop from empty queue")
  `TRSF_ASSERT_ALWAYS(a_cnt_range, clk, rst_n, cnt_r != 2'd3, "queue count overflow")
  `TRSF_ASSERT_NEXT(a_cnt_track, clk, rst_n, push && !q_pop, cnt_r == $past(cnt_r) + 2'd1,
    "queue count did not advance")

endmodule

// ----- design/trsf_back.sv -----
// ----------------------------------------------------------------------------
// trsf_back
// Scan recent slots one per cycle, produce the result, commit pending entries.
// ----------------------------------------------------------------------------
module trsf_back
  import trsf_pkg::*;
#(
  parameter int SLOTS   = 8,
  parameter int PENDING = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  output logic        q_pop,
  input  work_t       q_data,
  input  cfg_t        cfg,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_publish,
  output logic        out_to_lockout_log,
  output logic        out_slot_matched,
  output logic [2:0]  out_matched_slot,
  output logic [7:0]  out_record_strength
);

  `include "tolerant_repeat_suppression_filter_defines.svh"

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int PW = (PENDING > 1) ? $clog2(PENDING) : 1;
  localparam int CW = $clog2(PENDING + 1);

  back_state_t st_r, st_nxt;

  // Slot store: valid bits in flops, payload as plain registers.
  logic   [SLOTS-1:0] sval_r;
  alert_t             slot_r [SLOTS];
  alert_t             pend_r [PENDING];
  logic               pmatch_r [PENDING];
  logic   [SW-1:0]    pidx_r [PENDING];
  logic   [CW-1:0]    pcnt_r;
  logic   [SW-1:0]    rptr_r;

  work_t              cur_r;
  logic   [SW-1:0]    si_r;
  logic   [CW-1:0]    ci_r;
  logic               matched_r, publish_r;
  logic   [SW-1:0]    midx_r;

  // One slot compare per cycle.
  alert_t       s;
  logic [16:0]  fdiff;
  logic [8:0]   sdiff;
  logic [26:0]  latd, lond;
  logic         hit;
  logic [31:0]  elapsed;

  always_comb begin
    s     = slot_r[si_r];
    fdiff = (cur_r.alert.freq > s.freq) ? {1'b0, cur_r.alert.freq - s.freq}
                                        : {1'b0, s.freq - cur_r.alert.freq};
    sdiff = (cur_r.alert.strength > s.strength) ?
            {1'b0, cur_r.alert.strength - s.strength} :
            {1'b0, s.strength - cur_r.alert.strength};
    latd  = ($signed(cur_r.alert.lat) > $signed(s.lat)) ?
            27'($signed(cur_r.alert.lat) - $signed(s.lat)) :
            27'($signed(s.lat) - $signed(cur_r.alert.lat));
    lond  = ($signed(cur_r.alert.lon) > $signed(s.lon)) ?
            27'($signed(cur_r.alert.lon) - $signed(s.lon)) :
            27'($signed(s.lon) - $signed(cur_r.alert.lon));
    hit   = sval_r[si_r] && (cur_r.alert.band == s.band)
            && (fdiff <= {7'd0, cfg.freq_tol})
            && (sdiff <= {5'd0, cfg.str_tol})
            && (cur_r.alert.loc_valid == s.loc_valid)
            && (!s.loc_valid || ((latd <= {11'd0, cfg.loc_tol})
                              && (lond <= {11'd0, cfg.loc_tol})));
    elapsed = cur_r.alert.ts - s.ts;
  end

  logic scan_done;
  assign scan_done = hit || (si_r == SW'(SLOTS - 1));

  // Next state.
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE:   if (q_valid) st_nxt = ST_SCAN;
      ST_SCAN:   if (!cur_r.keep || scan_done) st_nxt = ST_RESULT;
      ST_RESULT: if (out_ready) st_nxt = cur_r.last ? ST_COMMIT : ST_IDLE;
      ST_COMMIT: if (ci_r >= pcnt_r) st_nxt = ST_IDLE;
      default:   st_nxt = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    q_pop               = (st_r == ST_IDLE) && q_valid;
    out_valid           = (st_r == ST_RESULT);
    out_publish         = publish_r;
    out_to_lockout_log  = publish_r && cur_r.supported;
    out_slot_matched    = matched_r;
    out_matched_slot    = 3'(midx_r);
    out_record_strength = cur_r.alert.strength;
  end

  logic [PW-1:0] cwi;
  logic [SW-1:0] tgt;
  assign cwi = ci_r[PW-1:0];
  assign tgt = pmatch_r[cwi] ? pidx_r[cwi] : rptr_r;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_data;
    end
    if (st_r == ST_SCAN && cur_r.keep && hit && !matched_r) begin
      midx_r <= si_r;
    end
    if (st_r == ST_COMMIT && ci_r < pcnt_r) begin
      slot_r[tgt] <= pend_r[cwi];
    end
    if (st_r == ST_SCAN && (!cur_r.keep || scan_done) && cur_r.keep
        && (!hit || elapsed >= {16'd0, cfg.min_repeat})
        && pcnt_r < CW'(PENDING)) begin
      pend_r[pcnt_r[PW-1:0]]   <= cur_r.alert;
      pmatch_r[pcnt_r[PW-1:0]] <= hit;
      pidx_r[pcnt_r[PW-1:0]]   <= si_r;
    end
    if (!rst_n) begin
      st_r      <= ST_IDLE;
      sval_r    <= '0;
      pcnt_r    <= '0;
      rptr_r    <= '0;
      si_r      <= '0;
      ci_r      <= '0;
      matched_r <= 1'b0;
      publish_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      unique case (st_r)
        ST_IDLE: begin
          si_r      <= '0;
          ci_r      <= '0;
          matched_r <= 1'b0;
          publish_r <= 1'b0;
          if (q_valid) midx_r <= '0;
        end
        ST_SCAN: begin
          if (!cur_r.keep) begin
            publish_r <= 1'b0;
          end else if (scan_done) begin
            matched_r <= hit;
            publish_r <= !hit || (elapsed >= {16'd0, cfg.min_repeat});
            if ((!hit || elapsed >= {16'd0, cfg.min_repeat}) && pcnt_r < CW'(PENDING))
              pcnt_r <= pcnt_r + CW'(1);
          end else begin
            si_r <= si_r + SW'(1);
          end
        end
        ST_RESULT: ;
        ST_COMMIT: begin
          if (ci_r < pcnt_r) begin
            sval_r[tgt] <= 1'b1;
            if (!pmatch_r[cwi])
              rptr_r <= (rptr_r == SW'(SLOTS - 1)) ? '0 : rptr_r + SW'(1);
            ci_r <= ci_r + CW'(1);
          end else begin
            pcnt_r <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  `TRSF_ASSERT_ALWAYS(a_pcnt_range, clk, rst_n, pcnt_r <= CW'(PENDING),
    "pending count beyond capacity")
  `TRSF_ASSERT_ALWAYS(a_pub_match, clk, rst_n, !(out_valid && out_to_lockout_log && !out_publish),
    "lockout log without publish")
  `TRSF_ASSERT_NEXT(a_commit_clear, clk, rst_n, st_r == ST_COMMIT && st_nxt == ST_IDLE,
    pcnt_r == '0, "pending list not emptied after commit")

endmodule

// ----- design/tolerant_repeat_suppression_filter.sv -----
// ----------------------------------------------------------------------------
// tolerant_repeat_suppression_filter
// Drop or publish radar alerts, suppressing repeats of recent slots.
// ----------------------------------------------------------------------------
// Flow: an accepted alert passes the queue, then the back end's scan (one slot
// compared a cycle, stopping at the first hit) and result states. A frame_last
// alert adds a commit state, one pending entry written per cycle.
// A two-entry queue takes new alerts while the back end works or stalls.
// Reset (rst_n low, synchronous) clears slot valid bits, pointers, counts and
// restores configuration defaults.
module tolerant_repeat_suppression_filter
  import trsf_pkg::*;
#(
  parameter int RECENT_SLOTS = 8,
  parameter int MAX_PENDING  = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        in_timestamp_ms,
  input  logic               in_alert_valid,
  input  logic [7:0]         in_band_code,
  input  logic               in_band_supported,
  input  logic [7:0]         in_front_strength,
  input  logic [7:0]         in_rear_strength,
  input  logic [15:0]        in_frequency_mhz,
  input  logic               in_location_valid,
  input  logic signed [24:0] in_latitude_e5,
  input  logic signed [25:0] in_longitude_e5,
  input  logic               in_frame_last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_publish,
  output logic               out_to_lockout_log,
  output logic               out_slot_matched,
  output logic [2:0]         out_matched_slot,
  output logic [7:0]         out_record_strength,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  cfg_t  cfg_r;
  logic  q_valid, q_pop;
  work_t q_data;

  // Configuration registers; writes land at any time.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_repeat <= 16'd1500;
      cfg_r.freq_tol   <= 10'd5;
      cfg_r.str_tol    <= 4'd1;
      cfg_r.loc_tol    <= 16'd25;
      cfg_r.capture    <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MIN_REPEAT: cfg_r.min_repeat <= cfg_data;
        REG_FREQ_TOL:   cfg_r.freq_tol   <= cfg_data[9:0];
        REG_STR_TOL:    cfg_r.str_tol    <= cfg_data[3:0];
        REG_LOC_TOL:    cfg_r.loc_tol    <= cfg_data;
        REG_CAPTURE:    cfg_r.capture    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Front: accept and classify.
  trsf_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_timestamp_ms, .in_alert_valid,
    .in_band_code, .in_band_supported, .in_front_strength, .in_rear_strength,
    .in_frequency_mhz, .in_location_valid, .in_latitude_e5, .in_longitude_e5,
    .in_frame_last, .capture(cfg_r.capture),
    .q_valid, .q_pop, .q_data
  );

  // Back: slot scan, result, frame commit.
  trsf_back #(.SLOTS(RECENT_SLOTS), .PENDING(MAX_PENDING)) u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_data, .cfg(cfg_r),
    .out_valid, .out_ready, .out_publish, .out_to_lockout_log,
    .out_slot_matched, .out_matched_slot, .out_record_strength
  );

endmodule

// ----- tb/tolerant_repeat_suppression_filter_checker.sv -----
// ----------------------------------------------------------------------------
// tolerant_repeat_suppression_filter_checker
// Watches the alert, result and register channels of the filter, keeps a
// cycle-free model of its slots and pending list, and compares each result.
// ----------------------------------------------------------------------------
module tolerant_repeat_suppression_filter_checker
  import trsf_pkg::*;
#(
  parameter int SLOT_COUNT  = 8,
  parameter int PEND_LIMIT  = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [31:0]        in_timestamp_ms,
  input  logic               in_alert_valid,
  input  logic [7:0]         in_band_code,
  input  logic               in_band_supported,
  input  logic [7:0]         in_front_strength,
  input  logic [7:0]         in_rear_strength,
  input  logic [15:0]        in_frequency_mhz,
  input  logic               in_location_valid,
  input  logic signed [24:0] in_latitude_e5,
  input  logic signed [25:0] in_longitude_e5,
  input  logic               in_frame_last,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               out_publish,
  input  logic               out_to_lockout_log,
  input  logic               out_slot_matched,
  input  logic [2:0]         out_matched_slot,
  input  logic [7:0]         out_record_strength,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output int                 fail_count,
  output int                 outstanding
);

  typedef struct packed {
    logic       publish;
    logic       to_log;
    logic       matched;
    logic [2:0] slot;
    logic [7:0] strength;
  } verdict_t;

  typedef struct {
    alert_t     alert;
    logic       has_match;
    logic [2:0] slot;
  } memo_t;

  cfg_t     regs;
  logic     slot_ok [SLOT_COUNT];
  alert_t   slot_alert [SLOT_COUNT];
  int       victim;
  memo_t    memos [$];
  verdict_t verdicts [$];

  assign outstanding = verdicts.size();

  function automatic longint span(longint a, longint b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic bit alike(alert_t a, alert_t b);
    if (a.band != b.band) return 0;
    if (span(a.freq, b.freq) > regs.freq_tol) return 0;
    if (span(a.strength, b.strength) > regs.str_tol) return 0;
    if (a.loc_valid != b.loc_valid) return 0;
    if (!a.loc_valid) return 1;
    return span(a.lat, b.lat) <= regs.loc_tol && span(a.lon, b.lon) <= regs.loc_tol;
  endfunction

  // Judge one alert against the committed slots and update the model.
  task automatic judge_alert();
    alert_t   a;
    verdict_t v;
    logic     keep;
    logic [31:0] age;
    memo_t    m;
    a.ts        = in_timestamp_ms;
    a.band      = in_band_code;
    a.freq      = in_frequency_mhz;
    a.strength  = (in_front_strength > in_rear_strength) ? in_front_strength
                                                         : in_rear_strength;
    a.loc_valid = in_location_valid;
    a.lat       = in_location_valid ? in_latitude_e5 : '0;
    a.lon       = in_location_valid ? in_longitude_e5 : '0;
    v = '0;
    v.strength = a.strength;
    keep = in_alert_valid && (in_band_supported || regs.capture);
    if (keep) begin
      v.publish = 1'b1;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (slot_ok[i] && alike(a, slot_alert[i])) begin
          v.matched = 1'b1;
          v.slot    = i[2:0];
          age       = a.ts - slot_alert[i].ts;
          v.publish = age >= {16'd0, regs.min_repeat};
          break;
        end
      end
      if (v.publish && memos.size() < PEND_LIMIT) begin
        m.alert = a;
        m.has_match = v.matched;
        m.slot = v.slot;
        memos.push_back(m);
      end
    end
    v.to_log = v.publish && in_band_supported;
    if (in_frame_last) begin
      foreach (memos[k]) begin
        int idx;
        if (memos[k].has_match) idx = memos[k].slot;
        else begin
          idx    = victim;
          victim = (victim + 1) % SLOT_COUNT;
        end
        slot_alert[idx] = memos[k].alert;
        slot_ok[idx]    = 1'b1;
      end
      memos.delete();
    end
    verdicts.push_back(v);
  endtask

  task automatic report(string what, int got, int want);
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      regs    <= '{min_repeat: 16'd1500, freq_tol: 10'd5, str_tol: 4'd1,
                   loc_tol: 16'd25, capture: 1'b0};
      victim  = 0;
      memos.delete();
      verdicts.delete();
      fail_count = 0;
      for (int i = 0; i < SLOT_COUNT; i++) slot_ok[i] = 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MIN_REPEAT: regs.min_repeat <= cfg_data;
          REG_FREQ_TOL:   regs.freq_tol   <= cfg_data[9:0];
          REG_STR_TOL:    regs.str_tol    <= cfg_data[3:0];
          REG_LOC_TOL:    regs.loc_tol    <= cfg_data;
          REG_CAPTURE:    regs.capture    <= cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (verdicts.size() == 0) begin
          report("unexpected result", 1, 0);
        end else begin
          verdict_t w;
          w = verdicts.pop_front();
          if (out_publish !== w.publish) report("publish", out_publish, w.publish);
          if (out_to_lockout_log !== w.to_log)
            report("to_lockout_log", out_to_lockout_log, w.to_log);
          if (out_slot_matched !== w.matched)
            report("slot_matched", out_slot_matched, w.matched);
          if (out_matched_slot !== w.slot)
            report("matched_slot", out_matched_slot, w.slot);
          if (out_record_strength !== w.strength)
            report("record_strength", out_record_strength, w.strength);
        end
      end
      // Model acts after the result pop so a same-edge result is not confused.
      if (in_valid && in_ready) judge_alert();
    end
  end

endmodule

// ----- tb/tolerant_repeat_suppression_filter_tb.sv -----
// ----------------------------------------------------------------------------
// tolerant_repeat_suppression_filter_tb
// Drives directed and random alert frames through the filter under several
// register settings and idle patterns; a checker beside the block predicts
// and compares every result.
// ----------------------------------------------------------------------------
module tolerant_repeat_suppression_filter_tb;
  import trsf_pkg::*;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [31:0]        in_timestamp_ms = '0;
  logic               in_alert_valid = 1'b0;
  logic [7:0]         in_band_code = '0;
  logic               in_band_supported = 1'b0;
  logic [7:0]         in_front_strength = '0;
  logic [7:0]         in_rear_strength = '0;
  logic [15:0]        in_frequency_mhz = '0;
  logic               in_location_valid = 1'b0;
  logic signed [24:0] in_latitude_e5 = '0;
  logic signed [25:0] in_longitude_e5 = '0;
  logic               in_frame_last = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_publish;
  logic               out_to_lockout_log;
  logic               out_slot_matched;
  logic [2:0]         out_matched_slot;
  logic [7:0]         out_record_strength;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;

  int fail_count;
  int outstanding;

  // Idle percentages and a receiver hold-off count; updated per phase.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off_cycles = 0;

  // Clock stamp; advances slowly so repeat intervals are exercised.
  logic [31:0] clock_ms = 32'd0;

  // A small pool of remembered alerts so repeats actually hit the slots.
  typedef struct packed {
    logic [7:0]         band;
    logic [15:0]        freq;
    logic [7:0]         strength;
    logic               loc_valid;
    logic signed [24:0] lat;
    logic signed [25:0] lon;
  } seed_t;
  seed_t pool [8];

  always #6 clk = ~clk;

  tolerant_repeat_suppression_filter u_dut (.*);

  tolerant_repeat_suppression_filter_checker u_chk (
    .clk, .rst_n, .in_valid, .in_ready, .in_timestamp_ms, .in_alert_valid,
    .in_band_code, .in_band_supported, .in_front_strength, .in_rear_strength,
    .in_frequency_mhz, .in_location_valid, .in_latitude_e5, .in_longitude_e5,
    .in_frame_last, .out_valid, .out_ready, .out_publish, .out_to_lockout_log,
    .out_slot_matched, .out_matched_slot, .out_record_strength, .cfg_valid,
    .cfg_ready, .cfg_index, .cfg_data, .fail_count, .outstanding
  );

  // Receiver: stall at random, or hold off for a long counted stretch.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      out_ready <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Send one alert transaction; hold valid until accepted. Valid stays up
  // after the accept only until the next call drives or drops it.
  task automatic send_alert(logic [31:0] ts, logic av, logic [7:0] band, logic sup,
                            logic [7:0] fr, logic [7:0] rr, logic [15:0] freq,
                            logic lv, logic signed [24:0] lat,
                            logic signed [25:0] lon, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_timestamp_ms   <= ts;
    in_alert_valid    <= av;
    in_band_code      <= band;
    in_band_supported <= sup;
    in_front_strength <= fr;
    in_rear_strength  <= rr;
    in_frequency_mhz  <= freq;
    in_location_valid <= lv;
    in_latitude_e5    <= lat;
    in_longitude_e5   <= lon;
    in_frame_last     <= last;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Wait for every expected result, then for the block to finish a commit.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic signed [24:0] rand_lat();
    return 25'($signed($urandom_range(18000000)) - 25'sd9000000);
  endfunction

  function automatic logic signed [25:0] rand_lon();
    return 26'($signed($urandom_range(36000000)) - 26'sd18000000);
  endfunction

  // Mostly near-repeats of pooled alerts, with some fresh and some junk.
  task automatic random_alert(logic last);
    seed_t s;
    int    pick;
    int    d;
    logic [7:0] fr, rr;
    pick = $urandom_range(99);
    clock_ms = clock_ms + $urandom_range(400);
    if (pick < 70) begin
      s = pool[$urandom_range(7)];
      d = $urandom_range(12);
      s.freq = 16'(s.freq + d - 6);
      s.strength = 8'(s.strength + $urandom_range(2) - 1);
      if (s.loc_valid) begin
        s.lat = 25'(s.lat + $signed($urandom_range(60)) - 30);
        s.lon = 26'(s.lon + $signed($urandom_range(60)) - 30);
      end
      if ($urandom_range(3) == 0) s.loc_valid = ~s.loc_valid;
    end else begin
      s.band = 8'($urandom);
      s.freq = 16'($urandom);
      s.strength = 8'($urandom);
      s.loc_valid = 1'($urandom);
      s.lat = rand_lat();
      s.lon = rand_lon();
      if (pick > 94) pool[$urandom_range(7)] = s;
    end
    if ($urandom_range(1)) begin
      fr = s.strength; rr = 8'($urandom_range(s.strength));
    end else begin
      rr = s.strength; fr = 8'($urandom_range(s.strength));
    end
    send_alert(($urandom_range(49) == 0) ? $urandom : clock_ms,
               $urandom_range(9) != 0, s.band, $urandom_range(4) != 0, fr, rr,
               s.freq, s.loc_valid, s.lat, s.lon, last);
  endtask

  // One frame of a few alerts; occasionally a long one to overflow pending.
  task automatic random_frame();
    int n;
    n = ($urandom_range(19) == 0) ? 20 : $urandom_range(1, 5);
    for (int i = 0; i < n; i++) random_alert(i == n - 1);
  endtask

  task automatic random_phase(int frames);
    for (int f = 0; f < frames; f++) random_frame();
  endtask

  task automatic set_regs(logic [15:0] rep, logic [15:0] ft, logic [15:0] st,
                          logic [15:0] lt, logic [15:0] cap);
    write_reg(REG_MIN_REPEAT, rep);
    write_reg(REG_FREQ_TOL, ft);
    write_reg(REG_STR_TOL, st);
    write_reg(REG_LOC_TOL, lt);
    write_reg(REG_CAPTURE, cap);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    for (int i = 0; i < 8; i++) begin
      pool[i] = '{band: 8'($urandom), freq: 16'($urandom), strength: 8'($urandom),
                  loc_valid: 1'($urandom), lat: rand_lat(), lon: rand_lon()};
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, drops, too-soon repeat, wraparound time, no location.
    send_alert(32'd100, 1, 8'd0, 1, 8'd0, 8'd255, 16'd0, 1, -25'sd9000000,
               -26'sd18000000, 0);
    send_alert(32'hFFFF_FFFF, 1, 8'd255, 1, 8'd255, 8'd0, 16'hFFFF, 1,
               25'sd9000000, 26'sd18000000, 1);
    send_alert(32'd200, 1, 8'd0, 1, 8'd1, 8'd0, 16'd5, 1, -25'sd8999975,
               -26'sd17999975, 0);
    send_alert(32'd1300, 1, 8'd255, 1, 8'd254, 8'd254, 16'd65530, 1,
               25'sd8999975, 26'sd17999975, 1);
    send_alert(32'd5000, 0, 8'd7, 1, 8'd10, 8'd20, 16'd24000, 0, 0, 0, 0);
    send_alert(32'd5000, 1, 8'd7, 0, 8'd30, 8'd20, 16'd24000, 0, 0, 0, 1);
    send_alert(32'd6000, 1, 8'd9, 1, 8'd3, 8'd3, 16'd10525, 0, 25'sd123, -26'sd77, 1);
    send_alert(32'd6100, 1, 8'd9, 1, 8'd4, 8'd3, 16'd10530, 0, 0, 0, 1);
    send_alert(32'd7600, 1, 8'd9, 1, 8'd2, 8'd3, 16'd10520, 0, 0, 0, 1);
    send_alert(32'd7700, 1, 8'd9, 1, 8'd3, 8'd3, 16'd10525, 1, 0, 0, 1);
    drain();
    set_regs(16'd0, 16'd1023, 16'd15, 16'd65535, 16'd1);
    send_alert(32'd10, 1, 8'd7, 0, 8'd50, 8'd60, 16'd24000, 0, 0, 0, 1);
    send_alert(32'd10, 1, 8'd7, 0, 8'd60, 8'd50, 16'd25023, 0, 0, 0, 1);
    send_alert(32'd11, 1, 8'd9, 1, 8'd4, 8'd3, 16'd11000, 1, 25'sd100, 26'sd100, 0);
    send_alert(32'd11, 1, 8'd9, 1, 8'd4, 8'd3, 16'd11000, 1, 25'sd100, 26'sd100, 1);

    // Random phases under different settings and idle patterns.
    drain();
    set_regs(16'd1500, 16'd5, 16'd1, 16'd25, 16'd0);
    random_phase(140);
    drain();
    set_regs(16'd65535, 16'd0, 16'd0, 16'd0, 16'd1);
    send_idle_pct = 59;
    random_phase(110);
    drain();
    set_regs(16'd300, 16'd8, 16'd2, 16'd40, 16'd1);
    send_idle_pct = 0;
    recv_stall_pct = 59;
    random_phase(110);

    // Long receiver hold-off while alerts keep coming: fill the block up.
    hold_off_cycles <= 300;
    random_phase(8);
    drain();
    set_regs(16'd800, 16'd3, 16'd1, 16'd10, 16'd0);
    send_idle_pct = 34;
    recv_stall_pct = 34;
    random_phase(110);

    // Sender pauses until every result is in, then a final burst.
    drain();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    random_phase(50);

    drain();
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog; far beyond the slowest legal run.
  initial begin
    #60000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/trsf_pkg.sv
design/trsf_front.sv
design/trsf_back.sv
design/tolerant_repeat_suppression_filter.sv
tb/tolerant_repeat_suppression_filter_checker.sv
tb/tolerant_repeat_suppression_filter_tb.sv
